// ----- hw/rtl/binomial_via_prime_exponents_defines.svh -----
// Assertion macros for the binomial coefficient block
`ifndef BINOMIAL_VIA_PRIME_EXPONENTS_DEFINES_SVH
`define BINOMIAL_VIA_PRIME_EXPONENTS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BPE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpe_pkg.sv -----
// -----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the binomial coefficient block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpe_pkg;

    localparam int MAX_N     = 64;
    localparam int N_W       = 7;
    localparam int COEF_W    = 61;
    localparam int ACC_W     = 64;
    localparam int EXP_W     = 7;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 64;

    // bit p is set when p is prime, p below 128
    localparam logic [127:0] PRIME_MASK = 128'h800228A2_02088288_28208A20_A08A28AC;

    // Job handed from front to back
    typedef struct packed {
        logic             bad;
        logic [N_W-1:0]   n;
        logic [N_W-1:0]   m;
    } job_t;

endpackage

// ----- hw/rtl/bpe_front.sv -----
// -----------------------------------------------------------------------------
// bpe_front
// Accepts request beats, flags invalid ones, and queues jobs (two entries).
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpe_front
    import bpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [N_W-1:0]       total_count,
    input  logic [N_W-1:0]       choose_count,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    job_t       new_job;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        new_job.n   = total_count;
        new_job.m   = choose_count;
        new_job.bad = (total_count > N_W'(MAX_N)) || (choose_count > total_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_job;
    end

endmodule

// ----- hw/rtl/bpe_back.sv -----
// -----------------------------------------------------------------------------
// bpe_back
// Sequencer: walks p = 2..n, picks primes from a constant table, sums
// Legendre exponents by stepping through multiples of each prime power,
// then multiplies p in e times.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpe_back
    import bpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  job_t                 job,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [COEF_W-1:0]    coefficient,
    output logic                 invalid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_LEG   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [N_W-1:0]   n_reg, m_reg, k_reg;
    logic [N_W-1:0]   p_reg;
    logic [N_W:0]     q_reg, j_reg;
    logic [EXP_W-1:0] e_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             bad_reg;
    logic             out_valid_reg;

    // j walks the multiples of the prime power q; each multiple up to n adds
    // one, minus one for each of m and n-m that it does not exceed
    logic [2*N_W:0]   q_mul;
    logic             j_in_n;
    logic             q_next_ok;
    logic [EXP_W-1:0] e_step;

    assign q_mul     = {{N_W{1'b0}}, q_reg} * {{(N_W+1){1'b0}}, p_reg};
    assign j_in_n    = (j_reg <= {1'b0, n_reg});
    assign q_next_ok = (q_mul <= {{(N_W+1){1'b0}}, n_reg});
    assign e_step    = EXP_W'(1) - EXP_W'(j_reg <= {1'b0, m_reg})
                       - EXP_W'(j_reg <= {1'b0, k_reg});

    assign job_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign res_valid   = out_valid_reg;
    assign coefficient = bad_reg ? '0 : acc_reg[COEF_W-1:0];
    assign invalid     = bad_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (job_valid && job_ready)
                         state_next = job.bad ? S_DONE : S_PRIME;
            S_PRIME: if (p_reg > n_reg)
                         state_next = S_DONE;
                     else if (PRIME_MASK[p_reg])
                         state_next = S_LEG;
            S_LEG:   if (!j_in_n && !q_next_ok)
                         state_next = S_MUL;
            S_MUL:   if (e_reg == '0)
                         state_next = S_PRIME;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid && job_ready)
                begin
                    n_reg   <= job.n;
                    m_reg   <= job.m;
                    k_reg   <= job.n - job.m;
                    bad_reg <= job.bad;
                    acc_reg <= ACC_W'(1);
                    p_reg   <= N_W'(2);
                end
            end
            S_PRIME:
            begin
                if (p_reg <= n_reg)
                begin
                    if (PRIME_MASK[p_reg])
                    begin
                        q_reg <= {1'b0, p_reg};
                        j_reg <= {1'b0, p_reg};
                        e_reg <= '0;
                    end
                    else
                        p_reg <= p_reg + N_W'(1);
                end
            end
            S_LEG:
            begin
                if (j_in_n)
                begin
                    e_reg <= e_reg + e_step;
                    j_reg <= j_reg + q_reg;
                end
                else if (q_next_ok)
                begin
                    q_reg <= q_mul[N_W:0];
                    j_reg <= q_mul[N_W:0];
                end
            end
            S_MUL:
            begin
                if (e_reg != '0)
                begin
                    acc_reg <= acc_reg * ACC_W'(p_reg);
                    e_reg   <= e_reg - EXP_W'(1);
                end
                else
                    p_reg <= p_reg + N_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/binomial_via_prime_exponents.sv -----
// -----------------------------------------------------------------------------
// binomial_via_prime_exponents
// C(n,m) from prime exponents (Legendre's formula).
// -----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | tdata: total_count[6:0], choose_count[13:7]
//  m_axis  | out | tdata: coefficient[60:0]; tuser: invalid
//
// One request at a time in the back sequencer: it visits each p from 2 to n+1,
// steps through each multiple of each prime power up to n and each power, and
// multiplies each prime in e times before moving on to the next p.
// Invalid requests skip the walk and go from idle straight to the done state.
// A two-entry queue holds new beats while the sequencer works; the result
// stays in its register until taken and blocks the next job meanwhile.
// Reset is asynchronous and clears only control state.
`timescale 1ns / 1ps
`include "binomial_via_prime_exponents_defines.svh"

module binomial_via_prime_exponents
    import bpe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,  // total_count, choose_count
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,  // coefficient
    output logic                    m_axis_tuser   // invalid
);

    logic              job_valid, job_ready;
    job_t              job;
    logic [COEF_W-1:0] coefficient;

    bpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .total_count  (s_axis_tdata[N_W-1:0]),
        .choose_count (s_axis_tdata[2*N_W-1:N_W]),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    bpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .coefficient (coefficient),
        .invalid     (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-COEF_W){1'b0}}, coefficient};

    `BPE_ASSERT_IMP(a_bad_zero, clk, rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0,
        "invalid result with nonzero coefficient")
    `BPE_ASSERT_IMP(a_no_take_busy, clk, rst_n, job_ready, !m_axis_tvalid,
        "sequencer took a job while result pending")
    `BPE_ASSERT_NEXT(a_result_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

// ----- tb/tb_binomial_via_prime_exponents.sv -----
// -----------------------------------------------------------------------------
// tb_binomial_via_prime_exponents
// Self-checking bench for the binomial coefficient block.
// -----------------------------------------------------------------------------
// Directed table (range edges, invalid requests, trivial m) followed by random
// requests, mostly valid ones. Every result beat is compared against a local
// prime-exponent predictor. Both stream sides idle at random.
`timescale 1ns / 1ps

module tb_binomial_via_prime_exponents;
    import bpe_pkg::*;

    localparam int RAND_ITEMS  = 1300;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              invalid;
    } coef_result_t;

    typedef struct {
        logic [N_W-1:0] n;
        logic [N_W-1:0] m;
        logic           known;
        coef_result_t   res;
    } request_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    coef_result_t pending_coefs[$];
    int           fail_count;
    int           cycle_count;
    int           out_gap;
    bit           send_done;
    request_row_t rows[$];

    binomial_via_prime_exponents i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int legendre_exp(int x, int p);
        int sum;
        sum = 0;
        while (x >= p)
        begin
            x = x / p;
            sum += x;
        end
        return sum;
    endfunction

    function automatic coef_result_t binomial_predict(logic [N_W-1:0] n, logic [N_W-1:0] m);
        coef_result_t r;
        logic [ACC_W-1:0] acc;
        bit is_p;
        int e;
        acc = ACC_W'(1);
        if (n > MAX_N || m > n)
        begin
            r.coefficient = '0;
            r.invalid = 1'b1;
            return r;
        end
        for (int p = 2; p <= n; p++)
        begin
            is_p = 1'b1;
            for (int t = 2; t * t <= p; t++)
                if (p % t == 0)
                    is_p = 1'b0;
            if (!is_p)
                continue;
            e = legendre_exp(n, p) - legendre_exp(m, p) - legendre_exp(n - m, p);
            for (int j = 0; j < e; j++)
                acc = acc * ACC_W'(p);
        end
        r.coefficient = acc[COEF_W-1:0];
        r.invalid = 1'b0;
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // one request beat; held until the handshake completes
    task automatic send_request(logic [N_W-1:0] n, logic [N_W-1:0] m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, m, n};
        pending_coefs.insert(pending_coefs.size(), binomial_predict(n, m));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_with_gap(logic [N_W-1:0] n, logic [N_W-1:0] m);
        int g;
        send_request(n, m);
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic request_row_t mk_row(int n, int m, int known, longint c, int inv);
        request_row_t r;
        r.n = N_W'(n);
        r.m = N_W'(m);
        r.known = 1'(known);
        r.res.coefficient = COEF_W'(c);
        r.res.invalid = 1'(inv);
        return r;
    endfunction

    function automatic void add_row(int n, int m, int known, longint c, int inv);
        rows.insert(rows.size(), mk_row(n, m, known, c, inv));
    endfunction

    // result side: random stalls, check against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_coefs.size() == 0)
                begin
                    $error("result beat with nothing pending: coef=%0d inv=%0b",
                           m_axis_tdata[COEF_W-1:0], m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    coef_result_t want;
                    want = pending_coefs.pop_front();
                    if (m_axis_tdata[COEF_W-1:0] !== want.coefficient)
                    begin
                        $error("coefficient: expected %0d, got %0d",
                               want.coefficient, m_axis_tdata[COEF_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.invalid)
                    begin
                        $error("invalid: expected %0b, got %0b", want.invalid, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                out_gap--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!send_done && $urandom_range(0, 2) == 0)
                    out_gap = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        int m;
        request_row_t row;
        fail_count    = 0;
        cycle_count   = 0;
        send_done     = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, 0, 1, 1, 0);
        add_row(1, 0, 1, 1, 0);
        add_row(1, 1, 1, 1, 0);
        add_row(0, 1, 1, 0, 1);
        add_row(5, 2, 1, 10, 0);
        add_row(64, 0, 1, 1, 0);
        add_row(64, 64, 1, 1, 0);
        add_row(64, 1, 1, 64, 0);
        add_row(64, 32, 0, 0, 0);
        add_row(64, 31, 0, 0, 0);
        add_row(63, 64, 1, 0, 1);
        add_row(65, 0, 1, 0, 1);
        add_row(127, 127, 1, 0, 1);
        add_row(127, 0, 1, 0, 1);
        add_row(0, 127, 1, 0, 1);
        add_row(2, 1, 1, 2, 0);
        add_row(47, 23, 0, 0, 0);
        add_row(60, 30, 0, 0, 0);
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.known && binomial_predict(row.n, row.m) !== row.res)
            begin
                $error("table row %0d: coefficient expected %0d, predictor %0d", i,
                       row.res.coefficient, binomial_predict(row.n, row.m).coefficient);
                fail_count++;
            end
            send_with_gap(row.n, row.m);
        end

        // drain completely once before the random part
        s_axis_tvalid <= 1'b0;
        while (pending_coefs.size() != 0)
            @(posedge clk);

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // mostly small n keeps the run short; some full range
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 24);
                m = $urandom_range(0, n);
            end
            else
            begin
                n = $urandom_range(0, 127);
                m = $urandom_range(0, 127);
            end
            send_with_gap(N_W'(n), N_W'(m));
        end
        s_axis_tvalid <= 1'b0;
        send_done = 1'b1;

        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending_coefs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
